// ===== src/u8d_pkg.sv =====
// UTF-8 stream decoder: shared types and constants.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

	localparam logic [7:0]  LEAD_MAX      = 8'hF4;
	localparam logic [7:0]  LEAD_MIN      = 8'hC2;
	localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
	localparam logic [7:0]  LEAD3_MIN     = 8'hE0;
	localparam logic [7:0]  LEAD4_MIN     = 8'hF0;
	localparam logic [7:0]  CONT_MASK     = 8'hC0;
	localparam logic [7:0]  CONT_TAG      = 8'h80;
	localparam logic [20:0] CP_LIMIT      = 21'h110000;
	localparam logic [20:0] SURR_LO       = 21'h00D800;
	localparam logic [20:0] SURR_HI       = 21'h00E000;
	localparam logic [20:0] MIN_3BYTE     = 21'h000800;
	localparam logic [20:0] MIN_4BYTE     = 21'h010000;
	localparam logic [20:0] REPL_CHAR     = 21'd63;      // '?'

	localparam logic [2:0]  LEN_NONE      = 3'd0;
	localparam logic [2:0]  LEN_1         = 3'd1;
	localparam logic [2:0]  LEN_2         = 3'd2;
	localparam logic [2:0]  LEN_3         = 3'd3;
	localparam logic [2:0]  LEN_4         = 3'd4;

	localparam int          PADDR_W       = 3;
	localparam logic        REG_STOP_IDX  = 1'b0;        // word index of stop_at_first_error

	// One queue entry: a run of '?' results, then an optional closing result.
	typedef struct packed {
		logic [2:0]  rep_cnt;
		logic        has_final;
		logic [20:0] code_point;
		logic [2:0]  seq_length;
		logic        end_of_string;
		logic        string_valid;
	} u8d_entry_t;

endpackage

`default_nettype wire

// ===== src/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder top level: input channel, APB register, front end,
// entry queue and back end. Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one UTF-8 byte per cycle into code points with '?' repair of bad
// bytes (or validation only, when stop_at_first_error is set). A byte is
// classified and entered in the queue in the cycle it is taken; the back end
// then emits its results at one per cycle while out_stall is low; a byte has
// zero to four results, usually one. The input is stalled only when the
// QUEUE_DEPTH-entry queue fills behind an error burst or a stalled output.
module utf8_stream_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [7:0]                   in_byte,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [20:0]                  code_point,
	output logic [2:0]                   seq_length,
	output logic                         bad_byte,
	output logic                         end_of_string,
	output logic                         string_valid,
	output logic                         last_result,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [u8d_pkg::PADDR_W-1:0]  paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import u8d_pkg::*;

	logic       stop_q;
	logic       accept;
	logic       push;
	logic       full;
	logic       pop;
	logic       head_valid;
	u8d_entry_t push_entry;
	u8d_entry_t head_entry;

	assign pready   = 1'b1;
	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign prdata   = (paddr[PADDR_W-1] == REG_STOP_IDX) ? {31'd0, stop_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
		             && (paddr[PADDR_W-1] == REG_STOP_IDX)) begin
			stop_q <= pwdata[0];
		end
	end

	u8d_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.accept              (accept),
		.in_byte             (in_byte),
		.stop_at_first_error (stop_q),
		.push                (push),
		.entry               (push_entry)
	);

	u8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	u8d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.seq_length    (seq_length),
		.bad_byte      (bad_byte),
		.end_of_string (end_of_string),
		.string_valid  (string_valid),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

// ===== src/u8d_front.sv =====
// UTF-8 stream decoder: front end. Classifies each byte, tracks the pending
// sequence and turns the byte into at most one queue entry. Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  wire [7:0]           in_byte,
	input  wire                 stop_at_first_error,
	output logic                push,
	output u8d_pkg::u8d_entry_t entry
);
	import u8d_pkg::*;

	logic [20:0] pv_q;
	logic [1:0]  rem_q;
	logic [1:0]  cons_q;
	logic [2:0]  slen_q;
	logic        err_q;

	logic [20:0] pv_n;
	logic [1:0]  rem_n;
	logic [1:0]  cons_n;
	logic [2:0]  slen_n;
	logic        err_n;

	logic [2:0]  rep;
	logic        fin;
	logic [20:0] fin_cp;
	logic [2:0]  fin_len;
	logic        fin_end;
	logic        fin_valid;
	logic        lead_go;
	logic        fin_keep;

	logic [1:0]  c_rem;
	logic [1:0]  c_cons;
	logic [20:0] c_bits;
	logic [20:0] c_pv;
	logic        c_bad;

	always_comb begin
		c_rem  = rem_q - 2'd1;
		c_cons = cons_q + 2'd1;
		case (c_rem)
			2'd0:    c_bits = {15'd0, in_byte[5:0]};
			2'd1:    c_bits = {9'd0, in_byte[5:0], 6'd0};
			2'd2:    c_bits = {3'd0, in_byte[5:0], 12'd0};
			default: c_bits = {in_byte[2:0], 18'd0};
		endcase
		c_pv  = pv_q | c_bits;
		c_bad = ((slen_q == LEN_4) && (c_cons == 2'd2) && (c_pv >= CP_LIMIT))
		     || ((slen_q == LEN_3) && (c_cons == 2'd2)
		         && (((c_pv >= SURR_LO) && (c_pv < SURR_HI)) || (c_pv < MIN_3BYTE)))
		     || ((slen_q == LEN_4) && (c_cons == 2'd3) && (c_pv < MIN_4BYTE));
	end

	always_comb begin
		pv_n      = pv_q;
		rem_n     = rem_q;
		cons_n    = cons_q;
		slen_n    = slen_q;
		err_n     = err_q;
		rep       = 3'd0;
		fin       = 1'b0;
		fin_cp    = 21'd0;
		fin_len   = LEN_NONE;
		fin_end   = 1'b0;
		fin_valid = 1'b0;
		lead_go   = 1'b0;

		if (stop_at_first_error && err_q && (in_byte != 8'd0)) begin
			pv_n   = 21'd0;
			rem_n  = 2'd0;
			cons_n = 2'd0;
			slen_n = LEN_NONE;
		end else if (rem_q != 2'd0) begin
			if ((in_byte & CONT_MASK) != CONT_TAG) begin
				// broken sequence: replace what was taken, then retry as a lead
				rep     = {1'b0, cons_q};
				err_n   = 1'b1;
				pv_n    = 21'd0;
				rem_n   = 2'd0;
				cons_n  = 2'd0;
				slen_n  = LEN_NONE;
				lead_go = 1'b1;
			end else if (c_bad) begin
				rep    = {1'b0, c_cons};
				err_n  = 1'b1;
				pv_n   = 21'd0;
				rem_n  = 2'd0;
				cons_n = 2'd0;
				slen_n = LEN_NONE;
			end else if (c_rem == 2'd0) begin
				fin     = 1'b1;
				fin_cp  = c_pv;
				fin_len = slen_q;
				pv_n    = 21'd0;
				rem_n   = 2'd0;
				cons_n  = 2'd0;
				slen_n  = LEN_NONE;
			end else begin
				pv_n   = c_pv;
				rem_n  = c_rem;
				cons_n = c_cons;
			end
		end else begin
			lead_go = 1'b1;
		end

		if (lead_go) begin
			if (in_byte == 8'd0) begin
				fin       = 1'b1;
				fin_end   = 1'b1;
				fin_valid = !err_n;
				err_n     = 1'b0;
				pv_n      = 21'd0;
				rem_n     = 2'd0;
				cons_n    = 2'd0;
				slen_n    = LEN_NONE;
			end else if (in_byte < ASCII_LIMIT) begin
				fin     = 1'b1;
				fin_cp  = {13'd0, in_byte};
				fin_len = LEN_1;
			end else if ((in_byte > LEAD_MAX) || (in_byte < LEAD_MIN)) begin
				rep    = rep + 3'd1;
				err_n  = 1'b1;
				pv_n   = 21'd0;
				rem_n  = 2'd0;
				cons_n = 2'd0;
				slen_n = LEN_NONE;
			end else if (in_byte < LEAD3_MIN) begin
				pv_n   = {10'd0, in_byte[4:0], 6'd0};
				slen_n = LEN_2;
				rem_n  = 2'd1;
				cons_n = 2'd1;
			end else if (in_byte < LEAD4_MIN) begin
				pv_n   = {5'd0, in_byte[3:0], 12'd0};
				slen_n = LEN_3;
				rem_n  = 2'd2;
				cons_n = 2'd1;
			end else begin
				pv_n   = {in_byte[2:0], 18'd0};
				slen_n = LEN_4;
				rem_n  = 2'd3;
				cons_n = 2'd1;
			end
		end

		// validate mode: once an error is flagged only the end marker survives
		fin_keep = fin && (fin_end || !(stop_at_first_error && err_n));
		if (stop_at_first_error)
			rep = 3'd0;

		entry.rep_cnt       = rep;
		entry.has_final     = fin_keep;
		entry.code_point    = fin_cp;
		entry.seq_length    = fin_len;
		entry.end_of_string = fin_end;
		entry.string_valid  = fin_valid;
		push = accept && ((rep != 3'd0) || fin_keep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= 21'd0;
			rem_q  <= 2'd0;
			cons_q <= 2'd0;
			slen_q <= LEN_NONE;
			err_q  <= 1'b0;
		end else if (accept) begin
			pv_q   <= pv_n;
			rem_q  <= rem_n;
			cons_q <= cons_n;
			slen_q <= slen_n;
			err_q  <= err_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/u8d_queue.sv =====
// UTF-8 stream decoder: small FIFO of result entries between front and back.
// Depends on u8d_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue #(
	parameter int DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  u8d_pkg::u8d_entry_t push_entry,
	output logic                full,
	input  wire                 pop,
	output logic                head_valid,
	output u8d_pkg::u8d_entry_t head_entry
);
	import u8d_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	u8d_entry_t     mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/u8d_back.sv =====
// UTF-8 stream decoder: back end. Expands one queue entry into its results
// and holds them in the output register. Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  u8d_pkg::u8d_entry_t head_entry,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [20:0]         code_point,
	output logic [2:0]          seq_length,
	output logic                bad_byte,
	output logic                end_of_string,
	output logic                string_valid,
	output logic                last_result
);
	import u8d_pkg::*;

	logic        out_valid_q;
	logic [2:0]  idx_q;
	logic [20:0] cp_q;
	logic [2:0]  len_q;
	logic        bad_q;
	logic        end_q;
	logic        sv_q;
	logic        last_q;

	logic        load;
	logic        in_rep;
	logic        last;
	logic [20:0] cp_d;
	logic [2:0]  len_d;

	always_comb begin
		load   = head_valid && (!out_valid_q || !out_stall);
		in_rep = (idx_q < head_entry.rep_cnt);
		if (in_rep) begin
			last  = ((idx_q + 3'd1) == head_entry.rep_cnt) && !head_entry.has_final;
			cp_d  = REPL_CHAR;
			len_d = LEN_1;
		end else begin
			last  = 1'b1;
			cp_d  = head_entry.code_point;
			len_d = head_entry.seq_length;
		end
		pop = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= cp_d;
			len_q  <= len_d;
			bad_q  <= in_rep;
			end_q  <= !in_rep && head_entry.end_of_string;
			sv_q   <= !in_rep && head_entry.string_valid;
			last_q <= last;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_point    = cp_q;
	assign seq_length    = len_q;
	assign bad_byte      = bad_q;
	assign end_of_string = end_q;
	assign string_valid  = sv_q;
	assign last_result   = last_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for utf8_stream_decoder_top: a directed byte table, then random
// UTF-8 sequences; results are checked against the table or a behavioral decoder in the bench.
// Depends on u8d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
	import u8d_pkg::*;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  seq_length;
		logic        bad_byte;
		logic        end_of_string;
		logic        string_valid;
		logic        last_result;
	} cp_result_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        typed;
		logic [20:0] cp;
		logic [2:0]  len;
		logic        bad;
		logic        eos;
		logic        ok;
	} dir_row_t;

	localparam logic [PADDR_W-1:0] STOP_REG_ADDR = PADDR_W'(4 * REG_STOP_IDX);
	localparam int NUM_DIR = 26;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 8;

	// rows with typed=1 carry their single result; the rest go through the decoder model
	dir_row_t dir_rows [NUM_DIR] = '{
		'{8'h00, 1'b1, 21'd0,   LEN_NONE, 1'b0, 1'b1, 1'b1},
		'{8'h7F, 1'b1, 21'd127, LEN_1,    1'b0, 1'b0, 1'b0},
		'{b: 8'hC2, default: '0}, '{b: 8'h80, default: '0},
		'{b: 8'hF4, default: '0}, '{b: 8'h8F, default: '0},
		'{b: 8'hBF, default: '0}, '{b: 8'hBF, default: '0},
		'{b: 8'hED, default: '0}, '{b: 8'hA0, default: '0},
		'{b: 8'hE0, default: '0}, '{b: 8'h9F, default: '0},
		'{b: 8'hF4, default: '0}, '{b: 8'h90, default: '0},
		'{b: 8'hF0, default: '0}, '{b: 8'h8F, default: '0}, '{b: 8'h80, default: '0},
		'{b: 8'hF0, default: '0}, '{b: 8'h90, default: '0}, '{b: 8'h80, default: '0},
		'{b: 8'hF5, default: '0},
		'{8'hFF, 1'b1, 21'd63,  LEN_1,    1'b1, 1'b0, 1'b0},
		'{8'hC0, 1'b1, 21'd63,  LEN_1,    1'b1, 1'b0, 1'b0},
		'{b: 8'hC3, default: '0}, '{b: 8'h00, default: '0},
		'{8'h00, 1'b1, 21'd0,   LEN_NONE, 1'b0, 1'b1, 1'b1}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [20:0] code_point;
	logic [2:0]  seq_length;
	logic        bad_byte;
	logic        end_of_string;
	logic        string_valid;
	logic        last_result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// decoder model state
	logic [20:0] acc_cp;
	logic [1:0]  cont_left;
	logic [1:0]  taken;
	logic [2:0]  announced_len;
	logic        string_err;
	logic        validate_only;

	cp_result_t  byte_results[$];
	cp_result_t  decoded_q[$];
	logic [7:0]  stim_bytes[$];
	cp_result_t  head;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sent_bytes = 0;
	int mismatches = 0;
	int hold_left = 0;
	logic hold_req;

	utf8_stream_decoder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.code_point(code_point), .seq_length(seq_length), .bad_byte(bad_byte),
		.end_of_string(end_of_string), .string_valid(string_valid),
		.last_result(last_result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic emit_result(input logic [20:0] cp, input logic [2:0] len,
			input logic bad, input logic eos, input logic ok);
		cp_result_t r;
		if (validate_only && string_err && !eos) return;
		if (byte_results.size() >= 4) return;
		r = '{cp, len, bad, eos, ok, 1'b0};
		byte_results.push_back(r);
	endtask

	task automatic drop_partial();
		acc_cp = '0;
		cont_left = '0;
		taken = '0;
		announced_len = LEN_NONE;
	endtask

	// '?' for every byte of the broken sequence
	task automatic replace_pending(input logic [1:0] count);
		string_err = 1'b1;
		repeat (int'(count)) emit_result(REPL_CHAR, LEN_1, 1'b1, 1'b0, 1'b0);
		drop_partial();
	endtask

	task automatic start_char(input logic [7:0] b);
		if (b == 8'h00) begin
			emit_result(21'd0, LEN_NONE, 1'b0, 1'b1, !string_err);
			string_err = 1'b0;
			drop_partial();
		end else if (b < ASCII_LIMIT) begin
			emit_result({13'd0, b}, LEN_1, 1'b0, 1'b0, 1'b0);
		end else if (b > LEAD_MAX || b < LEAD_MIN) begin
			replace_pending(2'd1);
		end else if (b < LEAD3_MIN) begin
			acc_cp = {10'd0, b[4:0], 6'd0};
			announced_len = LEN_2;
			cont_left = 2'd1;
			taken = 2'd1;
		end else if (b < LEAD4_MIN) begin
			acc_cp = {5'd0, b[3:0], 12'd0};
			announced_len = LEN_3;
			cont_left = 2'd2;
			taken = 2'd1;
		end else begin
			acc_cp = {b[2:0], 18'd0};
			announced_len = LEN_4;
			cont_left = 2'd3;
			taken = 2'd1;
		end
	endtask

	task automatic add_cont(input logic [7:0] b);
		logic bad;
		bad = 1'b0;
		if ((b & CONT_MASK) != CONT_TAG) begin
			replace_pending(taken);
			start_char(b);
			return;
		end
		cont_left = cont_left - 2'd1;
		taken = taken + 2'd1;
		acc_cp = acc_cp | (21'(b[5:0]) << (6 * cont_left));
		if (announced_len == LEN_4 && taken == 2'd2 && acc_cp >= CP_LIMIT)
			bad = 1'b1;
		if (announced_len == LEN_3 && taken == 2'd2 &&
				((acc_cp >= SURR_LO && acc_cp < SURR_HI) || acc_cp < MIN_3BYTE))
			bad = 1'b1;
		if (announced_len == LEN_4 && taken == 2'd3 && acc_cp < MIN_4BYTE)
			bad = 1'b1;
		if (bad) begin
			replace_pending(taken);
		end else if (cont_left == 2'd0) begin
			emit_result(acc_cp, announced_len, 1'b0, 1'b0, 1'b0);
			drop_partial();
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		cp_result_t r;
		byte_results.delete();
		if (validate_only && string_err && b != 8'h00) begin
			drop_partial();
			return;
		end
		if (cont_left != 2'd0)
			add_cont(b);
		else
			start_char(b);
		if (byte_results.size() != 0) begin
			r = byte_results.pop_back();
			r.last_result = 1'b1;
			byte_results.push_back(r);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic typed, input cp_result_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_byte(b);
		if (typed)
			decoded_q.push_back(typed_res);
		else
			foreach (byte_results[i]) decoded_q.push_back(byte_results[i]);
		sent_bytes++;
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= STOP_REG_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_validate_mode(input logic v);
		logic [31:0] rd;
		apb_access(1'b1, {31'd0, v}, rd);
		validate_only = v;
		@(posedge clk);
		apb_access(1'b0, 32'd0, rd);
		if (rd !== {31'd0, v}) report_mismatch("stop_at_first_error readback", rd, {31'd0, v});
	endtask

	// wait for all results, then give zero-result bytes time to leave the pipe
	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_sequence();
		int sel;
		int len;
		int keep;
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] seq[$];
		sel = $urandom_range(99);
		if (sel < 25) begin
			seq.push_back(8'($urandom_range(8'h7F, 1)));
		end else if (sel < 85) begin
			len = (sel < 45) ? 2 : (sel < 60) ? 3 : (sel < 75) ? 4 : $urandom_range(4, 2);
			case (len)
				2: begin
					lead = 8'($urandom_range(8'hDF, LEAD_MIN));
					lo = 8'h80;
					hi = 8'hBF;
				end
				3: begin
					lead = 8'($urandom_range(8'hEF, LEAD3_MIN));
					lo = (lead == LEAD3_MIN) ? 8'hA0 : 8'h80;
					hi = (lead == 8'hED) ? 8'h9F : 8'hBF;
				end
				default: begin
					lead = 8'($urandom_range(LEAD_MAX, LEAD4_MIN));
					lo = (lead == LEAD4_MIN) ? 8'h90 : 8'h80;
					hi = (lead == LEAD_MAX) ? 8'h8F : 8'hBF;
				end
			endcase
			seq.push_back(lead);
			seq.push_back(8'($urandom_range(hi, lo)));
			repeat (len - 2) seq.push_back(8'($urandom_range(8'hBF, 8'h80)));
			// truncated sequence followed by an arbitrary byte
			if (sel >= 75) begin
				keep = $urandom_range(len - 1, 1);
				while (seq.size() > keep) void'(seq.pop_back());
				seq.push_back(8'($urandom_range(255)));
			end
		end else if (sel < 93) begin
			seq.push_back(8'($urandom_range(255)));
		end else begin
			seq.push_back(8'h00);
		end
		foreach (seq[i]) stim_bytes.push_back(seq[i]);
	endtask

	task automatic run_random(input int n);
		sent_bytes = 0;
		while (sent_bytes < n) begin
			queue_sequence();
			while (stim_bytes.size() != 0) send_byte(stim_bytes.pop_front(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(code_point), 32'd0);
			end else begin
				head = decoded_q.pop_front();
				if (code_point !== head.code_point)
					report_mismatch("code_point", 32'(code_point), 32'(head.code_point));
				if (seq_length !== head.seq_length)
					report_mismatch("seq_length", 32'(seq_length), 32'(head.seq_length));
				if (bad_byte !== head.bad_byte)
					report_mismatch("bad_byte", 32'(bad_byte), 32'(head.bad_byte));
				if (end_of_string !== head.end_of_string)
					report_mismatch("end_of_string", 32'(end_of_string),
						32'(head.end_of_string));
				if (string_valid !== head.string_valid)
					report_mismatch("string_valid", 32'(string_valid), 32'(head.string_valid));
				if (last_result !== head.last_result)
					report_mismatch("last_result", 32'(last_result), 32'(head.last_result));
			end
		end
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("[utf8_stream_decoder_top] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		validate_only = 1'b0;
		string_err = 1'b0;
		drop_partial();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_validate_mode(1'b0);
		send_idle_pct = 9;
		recv_stall_pct = 81;
		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].typed, '{dir_rows[i].cp, dir_rows[i].len,
				dir_rows[i].bad, dir_rows[i].eos, dir_rows[i].ok, 1'b1});
		run_random(30);

		// long output hold-off while input keeps coming: queue fills, input stalls
		in_valid <= 1'b0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		run_random(15);

		drain();
		set_validate_mode(1'b1);
		send_idle_pct = 81;
		recv_stall_pct = 9;
		run_random(30);

		drain();
		set_validate_mode(1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(15);

		drain();
		set_validate_mode(1'b1);
		run_random(15);

		drain();
		if (mismatches == 0)
			$display("[utf8_stream_decoder_top] OK");
		else
			$display("[utf8_stream_decoder_top] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/utf8_stream_decoder_top.sv
bench/tb_top.sv
